@@ design/afmc_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and lookup tables for the fader to MIDI converter.
// No dependencies; used by afmc_event_calc and the top level.
package afmc_pkg;

    localparam int CHANNELS_DEF = 4;
    localparam int HYST_LIMIT   = 8;
    localparam int EDGE_LOW     = 3;
    localparam int EDGE_HIGH    = 124;
    localparam int SECOND_START = 64;
    localparam int SECOND_SPAN  = 105;
    localparam int CC_BASE      = 16;
    localparam int NOTE_BASE    = 100;
    localparam int FULL_SCALE   = 1024;
    localparam int SEVEN_MAX    = 127;
    localparam int MAX_EVENTS   = 3;

    typedef enum logic [1:0] {
        KIND_CC       = 2'd0,
        KIND_NOTE_ON  = 2'd1,
        KIND_NOTE_OFF = 2'd2
    } evt_kind_t;

    typedef enum logic [1:0] {
        CFG_INVERT_MASK  = 2'd0,
        CFG_ROTATE       = 2'd1,
        CFG_DUAL_RANGE   = 2'd2,
        CFG_VELOCITY     = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [3:0] invert_mask;
        logic       rotate_enable;
        logic       dual_range_mode;
        logic [6:0] note_velocity;
    } cfg_t;

    typedef struct packed {
        evt_kind_t  kind;
        logic [6:0] number;
        logic [6:0] value;
        logic       last;
    } event_t;

    typedef struct packed {
        event_t [MAX_EVENTS-1:0] events;
        logic [1:0]              count;
        logic                    store;
        logic [10:0]             sample;
        logic                    level_we;
        logic [6:0]              level;
    } calc_res_t;

    typedef logic [127:0][6:0] lut_t;

    // First controller: 3..124 maps onto 0..127.
    function automatic lut_t build_first_lut();
        lut_t t;
        int   i;
        t = '0;
        for (i = EDGE_LOW; i <= EDGE_HIGH; i++) begin
            t[i] = 7'(((i - EDGE_LOW) * SEVEN_MAX) / (EDGE_HIGH - EDGE_LOW));
        end
        return t;
    endfunction

    // Second controller: 64..124 maps onto 0..105.
    function automatic lut_t build_second_lut();
        lut_t t;
        int   i;
        t = '0;
        for (i = SECOND_START; i <= EDGE_HIGH; i++) begin
            t[i] = 7'(((i - SECOND_START) * SECOND_SPAN) / (EDGE_HIGH - SECOND_START));
        end
        return t;
    endfunction

    localparam lut_t FIRST_LUT  = build_first_lut();
    localparam lut_t SECOND_LUT = build_second_lut();

    // Reduce an 11-bit sample to 7 bits; only full-scale 1024 and above clamps.
    function automatic logic [6:0] to_seven(input logic [10:0] s);
        return s[10] ? 7'(SEVEN_MAX) : s[9:3];
    endfunction

endpackage

@@ design/afmc_event_calc.sv @@
`timescale 1ns / 1ps
// Single-pass event computation for one fader request: averaging, inversion,
// hysteresis, controller remapping and edge notes. Depends on afmc_pkg.
module afmc_event_calc (
    input  logic              ch_ok,
    input  logic [1:0]        channel,
    input  logic [9:0]        sample_a,
    input  logic [9:0]        sample_b,
    input  logic [9:0]        sample_c,
    input  logic [9:0]        sample_d,
    input  logic [10:0]       prev,
    input  logic [6:0]        level,
    input  afmc_pkg::cfg_t    cfg,
    output afmc_pkg::calc_res_t res
);

    logic [11:0] sum;
    logic [9:0]  avg;
    logic        invert;
    logic [10:0] s_raw;
    logic [10:0] diff;
    logic [10:0] s_new;
    logic [6:0]  v;
    logic [6:0]  p;
    logic        changed;
    logic        in_mid;
    logic        want_b;
    logic        upper;
    logic        note_lo_on;
    logic        note_lo_off;
    logic        note_hi_on;
    logic        note_hi_off;
    logic        want_note;
    logic [6:0]  cc_a;
    logic [6:0]  note_a;
    logic [6:0]  b_value;
    afmc_pkg::event_t ev_a;
    afmc_pkg::event_t ev_b;
    afmc_pkg::event_t ev_n;
    logic [1:0]  n_ab;

    always_comb begin
        sum    = 12'(sample_a) + 12'(sample_b) + 12'(sample_c) + 12'(sample_d);
        avg    = sum[11:2];
        invert = !cfg.rotate_enable && cfg.invert_mask[channel];
        s_raw  = invert ? (11'(afmc_pkg::FULL_SCALE) - {1'b0, avg}) : {1'b0, avg};
        diff   = (s_raw >= prev) ? (s_raw - prev) : (prev - s_raw);
        s_new  = (diff < 11'(afmc_pkg::HYST_LIMIT)) ? prev : s_raw;
        v      = afmc_pkg::to_seven(s_new);
        p      = afmc_pkg::to_seven(prev);
        changed = ch_ok && (v != p);

        in_mid = (v >= 7'(afmc_pkg::EDGE_LOW)) && (v <= 7'(afmc_pkg::EDGE_HIGH));
        upper  = v >= 7'(afmc_pkg::SECOND_START);
        want_b = in_mid && cfg.dual_range_mode && (upper || (level != 7'd0));
        b_value = upper ? afmc_pkg::SECOND_LUT[v] : 7'd0;

        // Only the first matching note rule fires.
        note_lo_on  = (v <= 7'(afmc_pkg::EDGE_LOW)) && (p > 7'(afmc_pkg::EDGE_LOW));
        note_lo_off = (v > 7'(afmc_pkg::EDGE_LOW)) && (p <= 7'(afmc_pkg::EDGE_LOW));
        note_hi_on  = (v >= 7'(afmc_pkg::EDGE_HIGH)) && (p < 7'(afmc_pkg::EDGE_HIGH));
        note_hi_off = (v < 7'(afmc_pkg::EDGE_HIGH)) && (p >= 7'(afmc_pkg::EDGE_HIGH));
        want_note   = cfg.dual_range_mode
                      && (note_lo_on || note_lo_off || note_hi_on || note_hi_off);

        cc_a   = 7'(afmc_pkg::CC_BASE) + {4'd0, channel, 1'b0};
        note_a = 7'(afmc_pkg::NOTE_BASE) + {4'd0, channel, 1'b0};

        ev_a.kind   = afmc_pkg::KIND_CC;
        ev_a.number = cc_a;
        ev_a.value  = afmc_pkg::FIRST_LUT[v];
        ev_a.last   = 1'b0;

        ev_b.kind   = afmc_pkg::KIND_CC;
        ev_b.number = cc_a + 7'd1;
        ev_b.value  = b_value;
        ev_b.last   = 1'b0;

        if (note_lo_on || note_lo_off) begin
            ev_n.number = note_a;
        end else begin
            ev_n.number = note_a + 7'd1;
        end
        // A jump from the low edge straight to the high edge reports the low note off.
        if (note_lo_on || (note_hi_on && !note_lo_off)) begin
            ev_n.kind  = afmc_pkg::KIND_NOTE_ON;
            ev_n.value = cfg.note_velocity;
        end else begin
            ev_n.kind  = afmc_pkg::KIND_NOTE_OFF;
            ev_n.value = 7'd0;
        end
        ev_n.last = 1'b0;

        // The second controller never appears without the first one.
        n_ab = {1'b0, in_mid} + {1'b0, want_b};

        res.events = '0;
        if (in_mid) begin
            res.events[0] = ev_a;
        end
        if (want_b) begin
            res.events[1] = ev_b;
        end
        if (want_note) begin
            res.events[n_ab] = ev_n;
        end
        res.count = changed ? (n_ab + {1'b0, want_note}) : 2'd0;
        if (res.count != 2'd0) begin
            res.events[res.count - 2'd1].last = 1'b1;
        end

        res.store    = changed;
        res.sample   = s_new;
        res.level_we = changed && want_b;
        res.level    = b_value;
    end

endmodule

@@ design/analog_fader_to_midi_converter_unit.sv @@
`timescale 1ns / 1ps
// Top level of the fader to MIDI converter: input register, state, event buffer.
// Depends on afmc_pkg and afmc_event_calc.

// A fader request (channel plus four 10-bit ADC reads) is registered, then
// processed combinationally into zero to three MIDI events that fill a
// three-entry event buffer driving the master port. Requests that produce at
// most one event can stream back to back while m_tready stays high; a request
// with n events holds the single output port until all n are taken, and the
// next one is processed in the cycle its predecessor's final event is taken.
// Hysteresis and the shared second-controller level depend on the previous
// request, which is why requests are processed strictly in order. After reset
// all stored samples and the second-controller level are zero, invert_mask and
// rotate_enable are 0, dual_range_mode is 1 and note_velocity is 127.
module analog_fader_to_midi_converter_unit #(
    parameter int CHANNELS = afmc_pkg::CHANNELS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    // s_tdata from bit 0: channel[1:0], sample_a[9:0], sample_b[9:0],
    // sample_c[9:0], sample_d[9:0], zero pad[5:0]
    input  logic [47:0] s_tdata,

    output logic        m_tvalid,
    input  logic        m_tready,
    // m_tdata from bit 0: event_kind[1:0], event_number[6:0], event_value[6:0]
    output logic [15:0] m_tdata,
    output logic        m_tlast,

    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [6:0]  cfg_wdata
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    afmc_pkg::cfg_t      cfg_reg;
    logic                in_valid_reg;
    logic [41:0]         in_data_reg;
    logic [10:0]         prev_reg [CHANNELS];
    logic [6:0]          level_reg;
    afmc_pkg::event_t    evt_reg [afmc_pkg::MAX_EVENTS];
    logic [1:0]          cnt_reg;

    logic                fire;
    logic                take;
    logic [1:0]          in_channel;
    logic [2:0]          ch_ext;
    logic [IDX_W-1:0]    idx;
    logic                ch_ok;
    logic [10:0]         prev_sel;
    afmc_pkg::calc_res_t res;

    assign take     = m_tvalid && m_tready;
    assign fire     = in_valid_reg && ((cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && m_tready));
    assign s_tready = !in_valid_reg || fire;

    assign m_tvalid = cnt_reg != 2'd0;
    assign m_tdata  = {evt_reg[0].value, evt_reg[0].number, evt_reg[0].kind};
    assign m_tlast  = evt_reg[0].last;

    assign in_channel = in_data_reg[1:0];
    assign ch_ext     = {1'b0, in_channel};
    assign idx        = ch_ext[IDX_W-1:0];
    assign ch_ok      = {2'b00, in_channel} < 4'(CHANNELS);
    assign prev_sel   = ch_ok ? prev_reg[idx] : 11'd0;

    afmc_event_calc u_calc (
        .ch_ok    (ch_ok),
        .channel  (in_channel),
        .sample_a (in_data_reg[11:2]),
        .sample_b (in_data_reg[21:12]),
        .sample_c (in_data_reg[31:22]),
        .sample_d (in_data_reg[41:32]),
        .prev     (prev_sel),
        .level    (level_reg),
        .cfg      (cfg_reg),
        .res      (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.invert_mask     <= 4'd0;
            cfg_reg.rotate_enable   <= 1'b0;
            cfg_reg.dual_range_mode <= 1'b1;
            cfg_reg.note_velocity   <= 7'd127;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                afmc_pkg::CFG_INVERT_MASK: cfg_reg.invert_mask     <= cfg_wdata[3:0];
                afmc_pkg::CFG_ROTATE:      cfg_reg.rotate_enable   <= cfg_wdata[0];
                afmc_pkg::CFG_DUAL_RANGE:  cfg_reg.dual_range_mode <= cfg_wdata[0];
                afmc_pkg::CFG_VELOCITY:    cfg_reg.note_velocity   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_data_reg <= s_tdata[41:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CHANNELS; i++) begin
                prev_reg[i] <= 11'd0;
            end
            level_reg <= 7'd0;
        end else if (fire) begin
            if (res.store) begin
                prev_reg[idx] <= res.sample;
            end
            if (res.level_we) begin
                level_reg <= res.level;
            end
        end
    end

    // The buffer is loaded only when empty or when its last entry leaves now.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else if (fire) begin
            cnt_reg <= res.count;
        end else if (take) begin
            cnt_reg <= cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            for (int i = 0; i < afmc_pkg::MAX_EVENTS; i++) begin
                evt_reg[i] <= res.events[i];
            end
        end else if (take) begin
            for (int i = 0; i < afmc_pkg::MAX_EVENTS - 1; i++) begin
                evt_reg[i] <= evt_reg[i+1];
            end
        end
    end

`ifndef ASSERT_OFF
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= 2'd3)
        else $error("event buffer count out of range");

    a_last_on_final: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd1) |-> evt_reg[0].last)
        else $error("final buffered event is not marked last");

    a_no_early_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg > 2'd1) |-> !evt_reg[0].last)
        else $error("last marker before the final event of a request");

    a_level_range: assert property (@(posedge aclk) disable iff (!aresetn)
        level_reg <= 7'(afmc_pkg::SECOND_SPAN))
        else $error("second controller level above its span");

    a_fire_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && (res.count != 2'd0)) |=> m_tvalid)
        else $error("events computed but not presented");
`endif

endmodule
